// File: design/sco_pkg.sv
// ----------------------------------------------------------------------------
// sco_pkg
// Shared codes and constants for the step order closure block.
// ----------------------------------------------------------------------------
package sco_pkg;

  localparam int unsigned ID_W = 7;

  localparam logic [ID_W-1:0] STEP_INIT = 7'd0;
  localparam logic [ID_W-1:0] STEP_GOAL = 7'd127;

  typedef enum logic [1:0] {
    OP_ADD_STEP  = 2'd0,
    OP_ADD_ORDER = 2'd1,
    OP_QUERY     = 2'd2
  } op_e;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NO_CHANGE = 2'd1;
  localparam logic [1:0] ST_BAD_ID    = 2'd2;

  // one result word
  typedef struct packed {
    logic [1:0] status;
    logic       maybe_concurrent;
    logic       maybe_after;
    logic       maybe_before;
    logic       ordered_before;
  } result_t;

  // merge unit outcome for one row
  typedef struct packed {
    logic hit;
  } merge_sts_t;

endpackage

// File: design/sco_row_mem.sv
// ----------------------------------------------------------------------------
// sco_row_mem
// Order matrix row store: one write and one registered read per cycle.
// A row never written since reset reads as zero.
// ----------------------------------------------------------------------------
module sco_row_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [DEPTH-1:0] wr_data_i,
  output logic [DEPTH-1:0] rd_data_o
);

  logic [DEPTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] rd_q;
  logic [DEPTH-1:0] row_vld_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= row_vld_q[rd_addr_i];
      if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// File: design/sco_merge.sv
// ----------------------------------------------------------------------------
// sco_merge
// Row update unit shared by all rows of a closure pass.
// Row k takes the successors of j when k is i or precedes i and does not
// already precede j.
// ----------------------------------------------------------------------------
module sco_merge
  import sco_pkg::*;
#(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic [WIDTH-1:0] row_i,
  input  logic [WIDTH-1:0] row_j_i,
  input  logic [IDX_W-1:0] idx_i_i,
  input  logic [IDX_W-1:0] idx_j_i,
  input  logic [IDX_W-1:0] idx_k_i,
  output merge_sts_t       sts_o,
  output logic [WIDTH-1:0] row_o
);

  logic [WIDTH-1:0] bit_j;
  logic [WIDTH-1:0] bit_k;

  assign bit_j = {{(WIDTH-1){1'b0}}, 1'b1} << idx_j_i;
  assign bit_k = {{(WIDTH-1){1'b0}}, 1'b1} << idx_k_i;

  assign sts_o.hit = ((idx_k_i == idx_i_i) || row_i[idx_i_i]) && !row_i[idx_j_i];
  assign row_o     = row_i | ((row_j_i | bit_j) & ~bit_k);

endmodule

// File: design/step_order_closure_top.sv
// ----------------------------------------------------------------------------
// step_order_closure_top
// Keeps a transitively closed strict order over plan steps 1..step_total
// (0 is the initial step, 127 the goal). A query, an add_step or a refused
// update steps through S_RD_B, S_EVAL and S_FINISH after the input word is
// accepted, and its result word is registered at the output in S_FINISH. An
// applied add_order adds S_CLOSE, one pass over the active rows through the
// row store (one read and one write port) and the shared merge unit, one row
// per cycle, before S_FINISH. The input is taken only while no item is in
// work, so a new word waits until the last result is registered. A finished
// result waits in its last state until the output register is free.
// Reset clears the matrix at once through per-row valid bits, no clearing
// pass.
// ----------------------------------------------------------------------------
module step_order_closure_top
  import sco_pkg::*;
#(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // operation[1:0], first_id[8:2], second_id[15:9]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // ordered_before[0], maybe_before[1], maybe_after[2],
                                 // maybe_concurrent[3], status[5:4], zero[7:6]
);

  localparam int unsigned IDX_W = $clog2(MAX_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_B,
    S_EVAL,
    S_CLOSE,
    S_FINISH
  } state_e;

  function automatic logic [IDX_W-1:0] id_to_idx(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] t;
    t = id - 7'd1;
    return t[IDX_W-1:0];
  endfunction

  state_e            state_q;
  logic [1:0]        op_q;
  logic [ID_W-1:0]   a_q, b_q;
  logic [ID_W-1:0]   total_q;
  logic [MAX_STEPS-1:0] row_a_q, row_j_q;
  logic [IDX_W-1:0]  kidx_q;
  result_t           res_q;
  logic              m_tvalid_q;
  logic [7:0]        m_tdata_q;

  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [MAX_STEPS-1:0] rd_data;
  logic [MAX_STEPS-1:0] new_row;
  merge_sts_t           msts;

  logic [ID_W-1:0] in_a, in_b;
  assign in_a = s_tdata[8:2];
  assign in_b = s_tdata[15:9];

  assign s_tready = (state_q == S_IDLE);
  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = m_tdata_q;

  // id classes and flags, evaluated while row b is on the read port
  logic ord_a, ord_b, known_a, known_b, same, ab, ba;
  logic mb, ma, mc;
  result_t eval_res;
  logic    do_close;

  assign ord_a   = (a_q != STEP_INIT) && (a_q <= total_q);
  assign ord_b   = (b_q != STEP_INIT) && (b_q <= total_q);
  assign known_a = (a_q == STEP_INIT) || (a_q == STEP_GOAL) || ord_a;
  assign known_b = (b_q == STEP_INIT) || (b_q == STEP_GOAL) || ord_b;
  assign same    = (a_q == b_q);
  assign ab      = ord_a && ord_b && !same && row_a_q[id_to_idx(b_q)];
  assign ba      = ord_a && ord_b && !same && rd_data[id_to_idx(a_q)];

  always_comb begin
    if (same) begin
      mb = 1'b0;
      ma = 1'b0;
    end else if (a_q == STEP_INIT || b_q == STEP_GOAL) begin
      mb = 1'b1;
      ma = 1'b0;
    end else if (a_q == STEP_GOAL || b_q == STEP_INIT) begin
      mb = 1'b0;
      ma = 1'b1;
    end else begin
      mb = !ba;
      ma = !ab;
    end
    mc = ord_a && ord_b && !same && !ab && !ba;

    eval_res = '0;
    if (known_a && known_b) begin
      eval_res.ordered_before   = ab;
      eval_res.maybe_before     = mb;
      eval_res.maybe_after      = ma;
      eval_res.maybe_concurrent = mc;
    end
    eval_res.status = ST_NO_CHANGE;
    do_close = 1'b0;
    case (op_q)
      OP_ADD_STEP: begin
        if (known_a) begin
          eval_res.status = ST_NO_CHANGE;
        end else if (a_q == total_q + 7'd1 && total_q < ID_W'(MAX_STEPS)) begin
          eval_res.status = ST_DONE;
        end else begin
          eval_res.status = ST_BAD_ID;
        end
      end
      OP_ADD_ORDER: begin
        if (!known_a || !known_b) begin
          eval_res.status = ST_BAD_ID;
        end else if (!ord_a || !ord_b || same || ab) begin
          eval_res.status = ST_NO_CHANGE;
        end else begin
          eval_res.status = ST_DONE;
          do_close        = 1'b1;
        end
      end
      OP_QUERY: begin
        eval_res.status = (known_a && known_b) ? ST_DONE : ST_BAD_ID;
      end
      default: eval_res.status = ST_NO_CHANGE;
    endcase
  end

  // read port schedule: a on accept, b next, then rows in ascending order
  always_comb begin
    case (state_q)
      S_IDLE:  rd_addr = id_to_idx(in_a);
      S_RD_B:  rd_addr = id_to_idx(b_q);
      S_EVAL:  rd_addr = '0;
      S_CLOSE: rd_addr = kidx_q + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  assign wr_en = (state_q == S_CLOSE) && msts.hit;

  sco_row_mem #(
    .DEPTH (MAX_STEPS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (kidx_q),
    .wr_data_i (new_row),
    .rd_data_o (rd_data)
  );

  sco_merge #(
    .WIDTH (MAX_STEPS),
    .IDX_W (IDX_W)
  ) u_merge (
    .row_i   (rd_data),
    .row_j_i (row_j_q),
    .idx_i_i (id_to_idx(a_q)),
    .idx_j_i (id_to_idx(b_q)),
    .idx_k_i (kidx_q),
    .sts_o   (msts),
    .row_o   (new_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      total_q    <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      op_q       <= '0;
      a_q        <= '0;
      b_q        <= '0;
      kidx_q     <= '0;
      row_a_q    <= '0;
      row_j_q    <= '0;
      res_q      <= '0;
    end else begin
      // in S_FINISH the valid flag is set below instead
      if (m_tvalid_q && m_tready && state_q != S_FINISH) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q    <= s_tdata[1:0];
            a_q     <= in_a;
            b_q     <= in_b;
            state_q <= S_RD_B;
          end
        end
        S_RD_B: begin
          row_a_q <= rd_data;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          row_j_q <= rd_data;
          res_q   <= eval_res;
          kidx_q  <= '0;
          if (op_q == OP_ADD_STEP && eval_res.status == ST_DONE) begin
            total_q <= a_q;
          end
          state_q <= do_close ? S_CLOSE : S_FINISH;
        end
        S_CLOSE: begin
          if (kidx_q == id_to_idx(total_q)) begin
            state_q <= S_FINISH;
          end else begin
            kidx_q <= kidx_q + 1'b1;
          end
        end
        S_FINISH: begin
          if (!m_tvalid_q || m_tready) begin
            m_tdata_q  <= {2'b00, res_q};
            m_tvalid_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
